FILE: rtl/core/lzss_stream_decoder_unit_defines.svh
// Assertion macros shared by the LZSS stream decoder RTL.
`ifndef LZSS_STREAM_DECODER_UNIT_DEFINES_SVH
`define LZSS_STREAM_DECODER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising edge outside reset.
`define LSD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lsd assertion failed");
// Next-cycle implication, checked at every rising edge outside reset.
`define LSD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lsd assertion failed");
`else
`define LSD_ASSERT_NOW(label, ante, cons)
`define LSD_ASSERT_NEXT(label, ante, cons)
`endif

`endif

FILE: rtl/core/lsd_pkg.sv
// Types and constants of the LZSS stream decoder.
`default_nettype none
package lsd_pkg;

  typedef logic [4:0] fw_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_BIT,
    ST_CPRD,
    ST_CPWR,
    ST_FLUSH
  } state_t;

  typedef enum logic [1:0] {
    PH_FLAG,
    PH_LITERAL,
    PH_LENGTH,
    PH_DISTANCE
  } phase_t;

  typedef struct packed {
    logic push;
    logic clear;
    logic bit_in;
    logic msb_first;
    fw_t  width;
  } field_ctl_t;

  localparam logic [1:0] CFG_BIT_ORDER     = 2'd0;
  localparam logic [1:0] CFG_LENGTH_BITS   = 2'd1;
  localparam logic [1:0] CFG_DISTANCE_BITS = 2'd2;

  localparam logic [4:0] MaxResults  = 5'd17;
  localparam fw_t        LitWidth    = 5'd8;
  localparam logic [2:0] MinLenBits  = 3'd1;
  localparam logic [2:0] MaxLenBits  = 3'd4;
  localparam logic [3:0] MinDistBits = 4'd4;
  localparam logic [4:0] LenBias     = 5'd2;
  localparam logic [3:0] CountSat    = 4'd15;

endpackage
`default_nettype wire

FILE: rtl/core/lsd_field_unit.sv
// Bit-serial field accumulator shared by literal, length and distance fields.
`default_nettype none
module lsd_field_unit #(
  parameter int AW = 12
) (
  input  wire                     clk,
  input  wire                     rst,
  input  lsd_pkg::field_ctl_t     ctl,
  output logic                    done,
  output logic [AW-1:0]           value
);
  import lsd_pkg::*;

  logic [AW-1:0] accum;
  logic [3:0]    count;
  logic [AW-1:0] accum_next;
  logic [3:0]    count_next;

  always_comb begin
    count_next = (count < CountSat) ? count + 4'd1 : CountSat;
    accum_next = accum;
    if (ctl.msb_first) begin
      accum_next = {accum[AW-2:0], ctl.bit_in};
    end else begin
      for (int i = 0; i < AW; i++) begin
        if (i == int'(count)) accum_next[i] = accum[i] | ctl.bit_in;
      end
    end
    done = ({1'b0, count_next} >= ctl.width);
    // keep only the bits inside the width in force
    for (int i = 0; i < AW; i++) begin
      value[i] = accum_next[i] & (i < int'(ctl.width));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accum <= '0;
      count <= '0;
    end else if (ctl.clear) begin
      accum <= '0;
      count <= '0;
    end else if (ctl.push) begin
      accum <= accum_next;
      count <= count_next;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/lsd_window_ram.sv
// History window memory: one write port, one registered read port.
`default_nettype none
module lsd_window_ram #(
  parameter int AW = 12
) (
  input  wire           clk,
  input  wire           we,
  input  wire  [AW-1:0] waddr,
  input  wire  [7:0]    wdata,
  input  wire           re,
  input  wire  [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (re) rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: rtl/core/lzss_stream_decoder_unit.sv
// LZSS stream decoder: one compressed byte in, zero or more decoded bytes out.
// Input channel in_valid/in_ready/in_byte takes one compressed byte per
// transaction; all eight bits are parsed into flag, literal, length and
// distance fields, and tokens may span bytes. Output channel
// out_valid/out_ready carries out_byte and last; last marks the final
// decoded byte caused by one input byte (at most 17 are delivered per input).
// Configuration channel cfg_valid/cfg_ready/cfg_index/cfg_data is always
// ready: index 0 bit order, 1 length field width, 2 distance field width.
// Sequence: each input byte is accepted in the idle state, then its eight bits
// are parsed one at a time, each copied byte takes a window read state and then
// a window write and emit state, and a flush state hands over the final result,
// if any; only then is the next byte accepted. The single window port pair and
// the bit-serial field unit set this pace.
// Reset: configuration returns to LSB first, length 4, distance 12; then a
// clearing pass zeroes every window entry with in_ready low.
// A stalled receiver holds one result in the output register and one pending;
// parsing pauses until there is room, and no result is lost.
`default_nettype none
`include "lzss_stream_decoder_unit_defines.svh"
module lzss_stream_decoder_unit #(
  parameter int WINDOW_BITS = 12
) (
  input  wire        clk,
  input  wire        rst,
  input  wire        in_valid,
  output logic       in_ready,
  input  wire  [7:0] in_byte,
  output logic       out_valid,
  input  wire        out_ready,
  output logic [7:0] out_byte,
  output logic       last,
  input  wire        cfg_valid,
  output logic       cfg_ready,
  input  wire  [1:0] cfg_index,
  input  wire  [3:0] cfg_data
);
  import lsd_pkg::*;

  localparam int WB = WINDOW_BITS;
  localparam int FW = (WINDOW_BITS > 8) ? WINDOW_BITS : 8;

  // configuration
  logic       bit_order;
  logic [2:0] length_bits;
  logic [3:0] distance_bits;

  // control state
  state_t         state, state_next;
  phase_t         phase;
  logic [3:0]     bit_cnt;
  logic [7:0]     byte_reg;
  logic [4:0]     res_cnt;
  logic [4:0]     copy_length;
  logic [WB-1:0]  copy_dist;
  logic [WB-1:0]  write_pos;
  logic [WB-1:0]  clr_addr;
  logic           pend_valid;
  logic [7:0]     pend_byte;

  // datapath
  fw_t            eff_len;
  fw_t            eff_dist;
  logic [WB-1:0]  win_mask;
  logic [WB-1:0]  wp_inc;
  logic [WB-1:0]  src_addr;
  logic           cur_bit;
  logic           out_free;
  logic           room;
  field_ctl_t     fctl;
  logic           fdone;
  logic [FW-1:0]  fvalue;
  logic           emit;
  logic           to_pend;
  logic [7:0]     emit_data;
  logic           mem_we;
  logic [WB-1:0]  mem_waddr;
  logic [7:0]     mem_wdata;
  logic           mem_re;
  logic [7:0]     mem_rdata;

  always_comb begin
    if (length_bits < MinLenBits) eff_len = {2'b00, MinLenBits};
    else if (length_bits > MaxLenBits) eff_len = {2'b00, MaxLenBits};
    else eff_len = {2'b00, length_bits};
    if (distance_bits < MinDistBits) eff_dist = {1'b0, MinDistBits};
    else if ({1'b0, distance_bits} > 5'(WINDOW_BITS)) eff_dist = 5'(WINDOW_BITS);
    else eff_dist = {1'b0, distance_bits};
    for (int i = 0; i < WB; i++) begin
      win_mask[i] = (i < int'(eff_dist));
    end
  end

  assign wp_inc   = (write_pos + 1'b1) & win_mask;
  assign src_addr = (write_pos - copy_dist - 1'b1) & win_mask;
  assign cur_bit  = bit_order ? byte_reg[3'd7 - bit_cnt[2:0]] : byte_reg[bit_cnt[2:0]];
  assign out_free = !out_valid || out_ready;
  assign room     = !pend_valid || out_free;
  assign cfg_ready = 1'b1;

  lsd_field_unit #(.AW(FW)) u_field (
    .clk   (clk),
    .rst   (rst),
    .ctl   (fctl),
    .done  (fdone),
    .value (fvalue)
  );

  lsd_window_ram #(.AW(WB)) u_window (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (src_addr),
    .rdata (mem_rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (clr_addr == '1) state_next = ST_IDLE;
      ST_IDLE:  if (in_valid) state_next = ST_BIT;
      ST_BIT: begin
        if (room) begin
          if (phase == PH_DISTANCE && fdone) state_next = ST_CPRD;
          else if (bit_cnt[2:0] == 3'd7) state_next = ST_FLUSH;
        end
      end
      ST_CPRD: state_next = ST_CPWR;
      ST_CPWR: begin
        if (room) begin
          if (copy_length == 5'd1) begin
            state_next = bit_cnt[3] ? ST_FLUSH : ST_BIT;
          end else begin
            state_next = ST_CPRD;
          end
        end
      end
      ST_FLUSH: if (room) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready       = 1'b0;
    fctl.push      = 1'b0;
    fctl.clear     = 1'b0;
    fctl.bit_in    = cur_bit;
    fctl.msb_first = bit_order;
    emit           = 1'b0;
    emit_data      = fvalue[7:0];
    mem_re         = 1'b0;
    case (phase)
      PH_LITERAL: fctl.width = LitWidth;
      PH_LENGTH:  fctl.width = eff_len;
      default:    fctl.width = eff_dist;
    endcase
    case (state)
      ST_IDLE: in_ready = 1'b1;
      ST_BIT: begin
        if (room) begin
          fctl.push  = (phase != PH_FLAG);
          fctl.clear = (phase == PH_FLAG) || fdone;
          emit       = (phase == PH_LITERAL) && fdone;
        end
      end
      ST_CPRD: mem_re = 1'b1;
      ST_CPWR: begin
        emit      = room;
        emit_data = mem_rdata;
      end
      default: ;
    endcase
    to_pend   = emit && (res_cnt < MaxResults);
    mem_we    = emit || (state == ST_CLEAR);
    mem_waddr = (state == ST_CLEAR) ? clr_addr : (write_pos & win_mask);
    mem_wdata = (state == ST_CLEAR) ? 8'h00 : emit_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_order     <= 1'b0;
      length_bits   <= 3'd4;
      distance_bits <= 4'd12;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_BIT_ORDER:     bit_order     <= cfg_data[0];
        CFG_LENGTH_BITS:   length_bits   <= cfg_data[2:0];
        CFG_DISTANCE_BITS: distance_bits <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      phase       <= PH_FLAG;
      bit_cnt     <= '0;
      res_cnt     <= '0;
      copy_length <= '0;
      copy_dist   <= '0;
      write_pos   <= '0;
      clr_addr    <= '0;
      pend_valid  <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clr_addr <= clr_addr + 1'b1;
      if (in_valid && in_ready) begin
        byte_reg <= in_byte;
        bit_cnt  <= '0;
        res_cnt  <= '0;
      end
      if (state == ST_BIT && room) begin
        bit_cnt <= bit_cnt + 4'd1;
        case (phase)
          PH_FLAG:    phase <= cur_bit ? PH_LENGTH : PH_LITERAL;
          PH_LITERAL: if (fdone) phase <= PH_FLAG;
          PH_LENGTH: begin
            if (fdone) begin
              copy_length <= {1'b0, fvalue[3:0]} + LenBias;
              phase       <= PH_DISTANCE;
            end
          end
          default: begin
            if (fdone) begin
              copy_dist <= fvalue[WB-1:0];
              phase     <= PH_FLAG;
            end
          end
        endcase
      end
      if (state == ST_CPWR && room) copy_length <= copy_length - 5'd1;
      if (emit) write_pos <= wp_inc;

      // output register drains on its own; pending stage refills it
      if (to_pend) begin
        res_cnt    <= res_cnt + 5'd1;
        pend_valid <= 1'b1;
        pend_byte  <= emit_data;
        if (pend_valid) begin
          out_valid <= 1'b1;
          out_byte  <= pend_byte;
          last      <= 1'b0;
        end else if (out_ready) begin
          out_valid <= 1'b0;
        end
      end else if (state == ST_FLUSH && pend_valid && out_free) begin
        pend_valid <= 1'b0;
        out_valid  <= 1'b1;
        out_byte   <= pend_byte;
        last       <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `LSD_ASSERT_NOW(a_idle_no_pending, in_ready, !pend_valid)
  `LSD_ASSERT_NOW(a_result_cap, 1'b1, res_cnt <= MaxResults)
  `LSD_ASSERT_NOW(a_copy_has_length, (state == ST_CPRD || state == ST_CPWR), copy_length != 5'd0)
  `LSD_ASSERT_NEXT(a_flush_marks_last, (state == ST_FLUSH && pend_valid && out_free), out_valid && last)

endmodule
`default_nettype wire
